// ===== design/tpa_pkg.sv =====
// Shared types and constants for the triangle plane and area unit.
package tpa_pkg;

  localparam int NUM_AXES = 3;

  // Pipeline control that every section receives from the top level.
  typedef struct packed {
    logic adv;
  } tpa_ctl_t;

endpackage

// ===== design/triangle_plane_and_area_unit.sv =====
// Top level of the triangle plane and area unit.
// Throughput: one request per cycle; the longer of the chain of square root stages and
// the chain of normal digit stages, one result bit per stage, sets the depth.
// The whole pipeline holds while a result is stalled.
// Reset clears only the valid bits of the pipeline; no clearing pass is needed.
module triangle_plane_and_area_unit import tpa_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_WIDTH-1:0]          in_v1_x,
  input  logic [COORD_WIDTH-1:0]          in_v1_y,
  input  logic [COORD_WIDTH-1:0]          in_v1_z,
  input  logic [COORD_WIDTH-1:0]          in_v2_x,
  input  logic [COORD_WIDTH-1:0]          in_v2_y,
  input  logic [COORD_WIDTH-1:0]          in_v2_z,
  input  logic [COORD_WIDTH-1:0]          in_v3_x,
  input  logic [COORD_WIDTH-1:0]          in_v3_y,
  input  logic [COORD_WIDTH-1:0]          in_v3_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [NORMAL_FRAC_BITS+1:0]     out_normal_x,
  output logic [NORMAL_FRAC_BITS+1:0]     out_normal_y,
  output logic [NORMAL_FRAC_BITS+1:0]     out_normal_z,
  output logic [COORD_WIDTH:0]            out_plane_offset,
  output logic [2*COORD_WIDTH:0]          out_area,
  output logic                            out_degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int NFB = NORMAL_FRAC_BITS;
  localparam logic signed [NFB+1:0] NRM_MAX = (NFB+2)'(1) << NFB;
  localparam logic signed [NFB+1:0] NRM_MIN = (NFB+2)'(0) - NRM_MAX;

  tpa_ctl_t ctl;
  logic [2:0][NUM_AXES-1:0][CW-1:0]  vtx;
  logic                              f_vld, i_vld;
  logic [NUM_AXES-1:0][4*CW+3:0]     f_csq;
  logic [NUM_AXES-1:0]               f_neg, i_neg;
  logic [NUM_AXES-1:0][CW-1:0]       f_v1, i_v1;
  logic [4*CW+5:0]                   i_s;
  logic [2*CW+2:0]                   i_root;
  logic [NUM_AXES-1:0][NFB+1:0]      i_k, b_nrm;

  assign ctl.adv  = !out_valid || !out_stall;
  assign in_stall = !ctl.adv;

  assign vtx[0][0] = in_v1_x;
  assign vtx[0][1] = in_v1_y;
  assign vtx[0][2] = in_v1_z;
  assign vtx[1][0] = in_v2_x;
  assign vtx[1][1] = in_v2_y;
  assign vtx[1][2] = in_v2_z;
  assign vtx[2][0] = in_v3_x;
  assign vtx[2][1] = in_v3_y;
  assign vtx[2][2] = in_v3_z;

  tpa_front #(.CW(CW)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .vld_i (in_valid),
    .vtx_i (vtx),
    .vld_o (f_vld),
    .csq_o (f_csq),
    .neg_o (f_neg),
    .v1_o  (f_v1)
  );

  tpa_iter #(.CW(CW), .NFB(NFB)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .vld_i  (f_vld),
    .csq_i  (f_csq),
    .neg_i  (f_neg),
    .v1_i   (f_v1),
    .vld_o  (i_vld),
    .s_o    (i_s),
    .root_o (i_root),
    .k_o    (i_k),
    .neg_o  (i_neg),
    .v1_o   (i_v1)
  );

  tpa_back #(.CW(CW), .NFB(NFB)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .vld_i    (i_vld),
    .s_i      (i_s),
    .root_i   (i_root),
    .k_i      (i_k),
    .neg_i    (i_neg),
    .v1_i     (i_v1),
    .vld_o    (out_valid),
    .nrm_o    (b_nrm),
    .offset_o (out_plane_offset),
    .area_o   (out_area),
    .deg_o    (out_degenerate)
  );

  assign out_normal_x = b_nrm[0];
  assign out_normal_y = b_nrm[1];
  assign out_normal_z = b_nrm[2];

  // A degenerate triangle carries no normal, offset or area.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == '0 && out_normal_y == '0 &&
      out_normal_z == '0 && out_plane_offset == '0 && out_area == '0)
    else $error("degenerate result with nonzero fields");

  // Any nonzero cross product has a length of at least one, so the area is nonzero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_area != '0)
    else $error("zero area on a proper triangle");

  // Unit normal components stay within plus or minus one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_normal_x) <= NRM_MAX && $signed(out_normal_x) >= NRM_MIN &&
      $signed(out_normal_y) <= NRM_MAX && $signed(out_normal_y) >= NRM_MIN &&
      $signed(out_normal_z) <= NRM_MAX && $signed(out_normal_z) >= NRM_MIN)
    else $error("normal component out of range");

  // A stalled result stays valid and keeps its fields until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normal_x) &&
      $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_plane_offset) &&
      $stable(out_area) && $stable(out_degenerate))
    else $error("stalled result changed");

endmodule

// ===== design/tpa_front.sv =====
// Front section: edge vectors, cross product and squared cross product components.
module tpa_front import tpa_pkg::*; #(
  parameter int CW = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tpa_ctl_t                                ctl,
  input  logic                                    vld_i,
  input  logic [2:0][NUM_AXES-1:0][CW-1:0]        vtx_i,
  output logic                                    vld_o,
  output logic [NUM_AXES-1:0][4*CW+3:0]           csq_o,
  output logic [NUM_AXES-1:0]                     neg_o,
  output logic [NUM_AXES-1:0][CW-1:0]             v1_o
);

  localparam int EW  = CW + 1;
  localparam int PRW = 2 * EW;
  localparam int CDW = PRW + 1;
  localparam int CMW = 2 * CW + 2;
  localparam int H   = CW + 1;
  localparam int CSW = 2 * CMW;

  logic signed [EW-1:0]  a_r [NUM_AXES];
  logic signed [EW-1:0]  b_r [NUM_AXES];
  logic signed [EW-1:0]  a_nxt [NUM_AXES];
  logic signed [EW-1:0]  b_nxt [NUM_AXES];
  logic signed [PRW-1:0] p_r [NUM_AXES];
  logic signed [PRW-1:0] q_r [NUM_AXES];
  logic signed [PRW-1:0] p_nxt [NUM_AXES];
  logic signed [PRW-1:0] q_nxt [NUM_AXES];
  logic signed [CDW-1:0] cdiff [NUM_AXES];
  logic [CMW-1:0]        mag_r [NUM_AXES];
  logic [CMW-1:0]        mag_nxt [NUM_AXES];
  logic [2*H-1:0]        hh_r [NUM_AXES];
  logic [2*H-1:0]        hl_r [NUM_AXES];
  logic [2*H-1:0]        ll_r [NUM_AXES];
  logic [CSW-1:0]        csq_r [NUM_AXES];
  logic [CSW-1:0]        csq_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]   negc_r, negc_nxt, negd_r, nege_r;
  logic [NUM_AXES-1:0][CW-1:0] v1a_r, v1b_r, v1c_r, v1d_r, v1e_r;
  logic [4:0]            vld_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      a_nxt[i] = $signed({vtx_i[1][i][CW-1], vtx_i[1][i]})
               - $signed({vtx_i[0][i][CW-1], vtx_i[0][i]});
      b_nxt[i] = $signed({vtx_i[2][i][CW-1], vtx_i[2][i]})
               - $signed({vtx_i[1][i][CW-1], vtx_i[1][i]});
    end
  end

  // Component i of a x b is p[i] - q[i].
  always_comb begin
    p_nxt[0] = PRW'(a_r[1]) * PRW'(b_r[2]);
    q_nxt[0] = PRW'(a_r[2]) * PRW'(b_r[1]);
    p_nxt[1] = PRW'(a_r[2]) * PRW'(b_r[0]);
    q_nxt[1] = PRW'(a_r[0]) * PRW'(b_r[2]);
    p_nxt[2] = PRW'(a_r[0]) * PRW'(b_r[1]);
    q_nxt[2] = PRW'(a_r[1]) * PRW'(b_r[0]);
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cdiff[i] = $signed({p_r[i][PRW-1], p_r[i]}) - $signed({q_r[i][PRW-1], q_r[i]});
      negc_nxt[i] = cdiff[i][CDW-1];
      mag_nxt[i] = cdiff[i][CDW-1] ? CMW'(-cdiff[i]) : cdiff[i][CMW-1:0];
    end
  end

  // The square is built from half-width partial products.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      csq_nxt[i] = (CSW'(hh_r[i]) << (2 * H)) + (CSW'(hl_r[i]) << (H + 1))
                 + CSW'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        a_r[i]   <= a_nxt[i];
        b_r[i]   <= b_nxt[i];
        p_r[i]   <= p_nxt[i];
        q_r[i]   <= q_nxt[i];
        mag_r[i] <= mag_nxt[i];
        hh_r[i]  <= (2*H)'(mag_r[i][CMW-1:H]) * (2*H)'(mag_r[i][CMW-1:H]);
        hl_r[i]  <= (2*H)'(mag_r[i][CMW-1:H]) * (2*H)'(mag_r[i][H-1:0]);
        ll_r[i]  <= (2*H)'(mag_r[i][H-1:0]) * (2*H)'(mag_r[i][H-1:0]);
        csq_r[i] <= csq_nxt[i];
      end
      v1a_r  <= vtx_i[0];
      v1b_r  <= v1a_r;
      v1c_r  <= v1b_r;
      v1d_r  <= v1c_r;
      v1e_r  <= v1d_r;
      negc_r <= negc_nxt;
      negd_r <= negc_r;
      nege_r <= negd_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      csq_o[i] = csq_r[i];
    end
  end

  assign vld_o = vld_r[4];
  assign neg_o = nege_r;
  assign v1_o  = v1e_r;

endmodule

// ===== design/tpa_iter.sv =====
// Iterative section: pipelined square root of the squared length and unit normal digits.
module tpa_iter import tpa_pkg::*; #(
  parameter int CW  = 24,
  parameter int NFB = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tpa_ctl_t                                ctl,
  input  logic                                    vld_i,
  input  logic [NUM_AXES-1:0][4*CW+3:0]           csq_i,
  input  logic [NUM_AXES-1:0]                     neg_i,
  input  logic [NUM_AXES-1:0][CW-1:0]             v1_i,
  output logic                                    vld_o,
  output logic [4*CW+5:0]                         s_o,
  output logic [2*CW+2:0]                         root_o,
  output logic [NUM_AXES-1:0][NFB+1:0]            k_o,
  output logic [NUM_AXES-1:0]                     neg_o,
  output logic [NUM_AXES-1:0][CW-1:0]             v1_o
);

  localparam int CSW = 4 * CW + 4;
  localparam int SW  = CSW + 2;
  localparam int RW  = 2 * CW + 3;
  localparam int KW  = NFB + 2;
  localparam int PW  = 2 * NFB + SW + 6;
  localparam int QW  = NFB + SW + 4;
  localparam int NS  = (RW > KW) ? RW : KW;

  typedef struct packed {
    logic [SW-1:0]                   s;
    logic [SW-1:0]                   rem;
    logic [RW-1:0]                   root;
    logic [NUM_AXES-1:0][CSW-1:0]    csq;
    logic [NUM_AXES-1:0]             neg;
    logic [NUM_AXES-1:0][CW-1:0]     v1;
    logic [NUM_AXES-1:0][PW-1:0]     p;
    logic [NUM_AXES-1:0][QW-1:0]     q;
    logic [NUM_AXES-1:0][KW-1:0]     k;
  } it_t;

  it_t  st_r   [NS+1];
  it_t  st_nxt [NS+1];
  logic vld_r  [NS+1];
  logic [SW-1:0] s0;

  // Digit search for each normal component keeps p = (2k-1)^2 * s and
  // q = (2k-1) * s, so a trial digit needs only shifts and adds.
  always_comb begin
    s0 = SW'(csq_i[0]) + SW'(csq_i[1]) + SW'(csq_i[2]);
    st_nxt[0].s    = s0;
    st_nxt[0].rem  = s0;
    st_nxt[0].root = '0;
    st_nxt[0].csq  = csq_i;
    st_nxt[0].neg  = neg_i;
    st_nxt[0].v1   = v1_i;
    for (int i = 0; i < NUM_AXES; i++) begin
      st_nxt[0].p[i] = PW'(s0);
      st_nxt[0].q[i] = QW'(0) - QW'(s0);
      st_nxt[0].k[i] = '0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [SW-1:0]               rem_n;
    logic [RW-1:0]               root_n;
    logic [NUM_AXES-1:0][PW-1:0] p_n;
    logic [NUM_AXES-1:0][QW-1:0] q_n;
    logic [NUM_AXES-1:0][KW-1:0] k_n;

    if (g < RW) begin : g_sq
      localparam int B = RW - 1 - g;
      logic [SW:0] trial;
      always_comb begin
        trial = ((SW+1)'(st_r[g].root) << (B + 1)) + ((SW+1)'(1) << (2 * B));
        if ({1'b0, st_r[g].rem} >= trial) begin
          rem_n  = st_r[g].rem - trial[SW-1:0];
          root_n = st_r[g].root | (RW'(1) << B);
        end else begin
          rem_n  = st_r[g].rem;
          root_n = st_r[g].root;
        end
      end
    end else begin : g_sq_hold
      assign rem_n  = st_r[g].rem;
      assign root_n = st_r[g].root;
    end

    if (g < KW) begin : g_nrm
      localparam int B = KW - 1 - g;
      logic [PW-1:0] pc [NUM_AXES];
      logic [PW-1:0] tt [NUM_AXES];
      always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
          pc[i] = st_r[g].p[i]
                + ({{(PW-QW){st_r[g].q[i][QW-1]}}, st_r[g].q[i]} << (B + 2))
                + (PW'(st_r[g].s) << (2 * B + 2));
          tt[i] = PW'(st_r[g].csq[i]) << (2 * NFB + 2);
          if (pc[i] <= tt[i]) begin
            p_n[i] = pc[i];
            q_n[i] = st_r[g].q[i] + (QW'(st_r[g].s) << (B + 1));
            k_n[i] = st_r[g].k[i] | (KW'(1) << B);
          end else begin
            p_n[i] = st_r[g].p[i];
            q_n[i] = st_r[g].q[i];
            k_n[i] = st_r[g].k[i];
          end
        end
      end
    end else begin : g_nrm_hold
      assign p_n = st_r[g].p;
      assign q_n = st_r[g].q;
      assign k_n = st_r[g].k;
    end

    always_comb begin
      st_nxt[g+1]      = st_r[g];
      st_nxt[g+1].rem  = rem_n;
      st_nxt[g+1].root = root_n;
      st_nxt[g+1].p    = p_n;
      st_nxt[g+1].q    = q_n;
      st_nxt[g+1].k    = k_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (ctl.adv) begin
      vld_r[0] <= vld_i;
      for (int j = 1; j <= NS; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int j = 0; j <= NS; j++) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign vld_o  = vld_r[NS];
  assign s_o    = st_r[NS].s;
  assign root_o = st_r[NS].root;
  assign k_o    = st_r[NS].k;
  assign neg_o  = st_r[NS].neg;
  assign v1_o   = st_r[NS].v1;

endmodule

// ===== design/tpa_back.sv =====
// Back section: signed normal, plane offset rounding and saturation, area.
module tpa_back import tpa_pkg::*; #(
  parameter int CW  = 24,
  parameter int NFB = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tpa_ctl_t                                ctl,
  input  logic                                    vld_i,
  input  logic [4*CW+5:0]                         s_i,
  input  logic [2*CW+2:0]                         root_i,
  input  logic [NUM_AXES-1:0][NFB+1:0]            k_i,
  input  logic [NUM_AXES-1:0]                     neg_i,
  input  logic [NUM_AXES-1:0][CW-1:0]             v1_i,
  output logic                                    vld_o,
  output logic [NUM_AXES-1:0][NFB+1:0]            nrm_o,
  output logic [CW:0]                             offset_o,
  output logic [2*CW:0]                           area_o,
  output logic                                    deg_o
);

  localparam int NW  = NFB + 2;
  localparam int PRW = NW + CW;
  localparam int DW  = PRW + 2;
  localparam int RW  = 2 * CW + 3;
  localparam int AW  = 2 * CW + 1;
  localparam int OW  = CW + 1;

  localparam logic [RW-1:0] AREA_MAX = RW'({AW{1'b1}});
  localparam logic [DW-1:0] POS_MAX  = (DW'(1) << CW) - DW'(1);
  localparam logic [DW-1:0] NEG_MAX  = DW'(1) << CW;
  localparam logic [DW-1:0] HALF     = DW'(1) << (NFB - 1);

  logic signed [NW-1:0]  n_r [NUM_AXES];
  logic signed [NW-1:0]  ny_r [NUM_AXES];
  logic signed [NW-1:0]  nz_r [NUM_AXES];
  logic signed [NW-1:0]  no_r [NUM_AXES];
  logic signed [NW-1:0]  n_nxt [NUM_AXES];
  logic signed [CW-1:0]  v1_r [NUM_AXES];
  logic signed [PRW-1:0] prod_r [NUM_AXES];
  logic [RW:0]           r1;
  logic [RW-1:0]         ahalf;
  logic [AW-1:0]         area_nxt, area_x_r, area_y_r, area_z_r, area_r;
  logic                  deg_nxt, deg_x_r, deg_y_r, deg_z_r, deg_r;
  logic signed [DW-1:0]  sdot;
  logic [DW-1:0]         u_r, u_nxt;
  logic                  spos_r;
  logic [DW-1:0]         d, dmax, dsat;
  logic                  dneg;
  logic [DW-1:0]         off_w;
  logic [OW-1:0]         off_r;
  logic [3:0]            vld_r;

  always_comb begin
    deg_nxt = (s_i == '0);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (deg_nxt) begin
        n_nxt[i] = '0;
      end else if (neg_i[i]) begin
        n_nxt[i] = $signed(NW'(0) - k_i[i]);
      end else begin
        n_nxt[i] = $signed(k_i[i]);
      end
    end
    // Half the length, rounded up from the integer root.
    r1       = {1'b0, root_i} + (RW+1)'(1);
    ahalf    = r1[RW:1];
    area_nxt = (ahalf > AREA_MAX) ? {AW{1'b1}} : ahalf[AW-1:0];
  end

  always_comb begin
    sdot = DW'(prod_r[0]) + DW'(prod_r[1]) + DW'(prod_r[2]);
    u_nxt = sdot[DW-1] ? DW'(-sdot) : DW'(sdot);
  end

  // The offset is minus the dot product, so a positive sum gives a negative offset unless it rounds to zero.
  always_comb begin
    d     = (u_r + HALF) >> NFB;
    dneg  = spos_r && (d != '0);
    dmax  = dneg ? NEG_MAX : POS_MAX;
    dsat  = (d > dmax) ? dmax : d;
    off_w = dneg ? (DW'(0) - dsat) : dsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        n_r[i]    <= n_nxt[i];
        v1_r[i]   <= $signed(v1_i[i]);
        prod_r[i] <= PRW'(n_r[i]) * PRW'(v1_r[i]);
        ny_r[i]   <= n_r[i];
        nz_r[i]   <= ny_r[i];
        no_r[i]   <= nz_r[i];
      end
      area_x_r <= area_nxt;
      area_y_r <= area_x_r;
      area_z_r <= area_y_r;
      area_r   <= area_z_r;
      deg_x_r  <= deg_nxt;
      deg_y_r  <= deg_x_r;
      deg_z_r  <= deg_y_r;
      deg_r    <= deg_z_r;
      u_r      <= u_nxt;
      spos_r   <= !sdot[DW-1] && (sdot != '0);
      off_r    <= off_w[OW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      nrm_o[i] = no_r[i];
    end
  end

  assign vld_o    = vld_r[3];
  assign offset_o = off_r;
  assign area_o   = area_r;
  assign deg_o    = deg_r;

endmodule
